### design/rcsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rcsd_pkg;

    // field widths
    localparam int W_SAMPLE   = 16;
    localparam int W_DZ       = 14;
    localparam int W_GAIN     = 18;
    localparam int W_CFG_DATA = 18;
    localparam int W_CFG_IDX  = 3;

    // fixed point: Q2.14 samples, Q4.14 gain
    localparam int FRAC_BITS = 14;
    localparam int W_PROD    = W_SAMPLE + W_GAIN;
    localparam int W_ROUND   = W_PROD + 1;
    localparam int W_SCALED  = W_ROUND - FRAC_BITS;

    // switch range check: 1.1 in Q2.14, truncated
    localparam logic signed [W_SAMPLE-1:0] SW_LIMIT = 16'sd18022;

    // register reset values
    localparam logic [W_DZ-1:0]            DEAD_ZONE_RST  = 14'd4096;
    localparam logic [W_GAIN-1:0]          STICK_GAIN_RST = 18'd21845;
    localparam logic signed [W_SAMPLE-1:0] MODE_TH_RST    = 16'sd12288;
    localparam logic signed [W_SAMPLE-1:0] GEAR_TH_RST    = 16'sd12288;
    localparam logic signed [W_SAMPLE-1:0] REBOOT_TH_RST  = 16'sd8192;

    // configuration register indexes
    typedef enum logic [W_CFG_IDX-1:0] {
        CFG_DEAD_ZONE  = 3'd0,
        CFG_STICK_GAIN = 3'd1,
        CFG_MODE_TH    = 3'd2,
        CFG_GEAR_TH    = 3'd3,
        CFG_REBOOT_TH  = 3'd4
    } t_cfg_reg;

endpackage

`default_nettype wire

### design/rcsd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rcsd_in_if;
    import rcsd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [W_SAMPLE-1:0] roll_in;
    logic signed [W_SAMPLE-1:0] pitch_in;
    logic signed [W_SAMPLE-1:0] throttle_in;
    logic signed [W_SAMPLE-1:0] yaw_in;
    logic signed [W_SAMPLE-1:0] mode_switch;
    logic signed [W_SAMPLE-1:0] gear_switch;
    logic signed [W_SAMPLE-1:0] reboot_switch;
    logic                       clear_hover_entry;

    modport source (
        output valid, roll_in, pitch_in, throttle_in, yaw_in,
               mode_switch, gear_switch, reboot_switch, clear_hover_entry,
        input  ready
    );

    modport sink (
        input  valid, roll_in, pitch_in, throttle_in, yaw_in,
               mode_switch, gear_switch, reboot_switch, clear_hover_entry,
        output ready
    );
endinterface

`default_nettype wire

### design/rcsd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rcsd_out_if;
    import rcsd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [W_SAMPLE-1:0] roll_out;
    logic signed [W_SAMPLE-1:0] pitch_out;
    logic signed [W_SAMPLE-1:0] throttle_out;
    logic signed [W_SAMPLE-1:0] yaw_out;
    logic                       hover_active;
    logic                       hover_entered;
    logic                       command_active;
    logic                       command_entered;
    logic                       reboot_request;
    logic                       switches_valid;

    modport source (
        output valid, roll_out, pitch_out, throttle_out, yaw_out,
               hover_active, hover_entered, command_active, command_entered,
               reboot_request, switches_valid,
        input  ready
    );

    modport sink (
        input  valid, roll_out, pitch_out, throttle_out, yaw_out,
               hover_active, hover_entered, command_active, command_entered,
               reboot_request, switches_valid,
        output ready
    );
endinterface

`default_nettype wire

### design/rcsd_stick.sv
`timescale 1ns / 1ps
`default_nettype none

module rcsd_stick
    import rcsd_pkg::*;
(
    input  wire logic signed [W_SAMPLE-1:0] i_x,
    input  wire logic        [W_DZ-1:0]     i_dead_zone,
    input  wire logic        [W_GAIN-1:0]   i_gain,
    output logic signed      [W_SAMPLE-1:0] o_y
);

    localparam logic [W_ROUND-1:0]  ROUND_HALF = W_ROUND'(1) << (FRAC_BITS - 1);
    localparam logic [W_SCALED-1:0] POS_MAX    = W_SCALED'(32767);
    localparam logic [W_SCALED-1:0] NEG_MAX    = W_SCALED'(32768);

    logic signed [W_SAMPLE:0] x_ext;
    logic signed [W_SAMPLE:0] dz_ext;
    logic signed [W_SAMPLE:0] diff;
    logic                     above;
    logic                     below;
    logic [W_SAMPLE-1:0]      mag;
    logic [W_PROD-1:0]        prod;
    logic [W_ROUND-1:0]       rounded;
    logic [W_SCALED-1:0]      scaled;

    // strict compare against the symmetric dead zone
    assign x_ext  = {i_x[W_SAMPLE-1], i_x};
    assign dz_ext = {{(W_SAMPLE + 1 - W_DZ){1'b0}}, i_dead_zone};
    assign above  = x_ext > dz_ext;
    assign below  = x_ext < -dz_ext;

    // distance beyond the edge, at most 32768 so it fits unsigned
    assign diff = above ? (x_ext - dz_ext) : (-x_ext - dz_ext);
    assign mag  = diff[W_SAMPLE-1:0];

    // gain, round half up on magnitude, drop fraction bits
    assign prod    = W_PROD'(mag) * W_PROD'(i_gain);
    assign rounded = W_ROUND'(prod) + ROUND_HALF;
    assign scaled  = rounded[W_ROUND-1:FRAC_BITS];

    // saturate and restore sign
    always_comb begin
        if (above) begin
            o_y = (scaled > POS_MAX) ? 16'sh7FFF : $signed(scaled[W_SAMPLE-1:0]);
        end else if (below) begin
            o_y = (scaled > NEG_MAX) ? 16'sh8000
                                     : $signed(W_SAMPLE'(~scaled[W_SAMPLE-1:0] + 16'd1));
        end else begin
            o_y = '0;
        end
    end

endmodule

`default_nettype wire

### design/rc_stick_deadzone_switch_decoder_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Radio-control frame decoder. Each accepted word is one frame: four sticks get
// a dead zone and a gain rescale with saturation, and the mode, gear and reboot
// channels are turned into hover, command and reboot flags by threshold and
// crossing tests against the previous frame. A frame is taken every cycle when
// the output side keeps up; each frame passes through the input register and
// then the result register, and the stick multipliers and the switch state
// update sit between them. The first frame after reset seeds the previous
// switch values. The user must write registers through the plain write port
// only while no frame is in flight; the block itself does not enforce this.

module rc_stick_deadzone_switch_decoder_top
    import rcsd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [W_CFG_IDX-1:0]  i_cfg_idx,
    input  wire logic [W_CFG_DATA-1:0] i_cfg_data,
    rcsd_in_if.sink                    i_in,
    rcsd_out_if.source                 o_out
);

    // configuration registers
    logic        [W_DZ-1:0]     r_dead_zone;
    logic        [W_GAIN-1:0]   r_stick_gain;
    logic signed [W_SAMPLE-1:0] r_mode_th;
    logic signed [W_SAMPLE-1:0] r_gear_th;
    logic signed [W_SAMPLE-1:0] r_reboot_th;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone  <= DEAD_ZONE_RST;
            r_stick_gain <= STICK_GAIN_RST;
            r_mode_th    <= MODE_TH_RST;
            r_gear_th    <= GEAR_TH_RST;
            r_reboot_th  <= REBOOT_TH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEAD_ZONE:  r_dead_zone  <= i_cfg_data[W_DZ-1:0];
                CFG_STICK_GAIN: r_stick_gain <= i_cfg_data[W_GAIN-1:0];
                CFG_MODE_TH:    r_mode_th    <= $signed(i_cfg_data[W_SAMPLE-1:0]);
                CFG_GEAR_TH:    r_gear_th    <= $signed(i_cfg_data[W_SAMPLE-1:0]);
                CFG_REBOOT_TH:  r_reboot_th  <= $signed(i_cfg_data[W_SAMPLE-1:0]);
                default: ;
            endcase
        end
    end

    // handshake: input register feeds result register
    logic r_s1_valid;
    logic r_s2_valid;
    logic s2_free;
    logic s1_adv;
    logic in_take;

    assign s2_free    = !r_s2_valid || o_out.ready;
    assign s1_adv     = r_s1_valid && s2_free;
    assign i_in.ready = !r_s1_valid || s2_free;
    assign in_take    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_s2_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    // input register
    logic signed [W_SAMPLE-1:0] r_s1_stick [4];
    logic signed [W_SAMPLE-1:0] r_s1_mode;
    logic signed [W_SAMPLE-1:0] r_s1_gear;
    logic signed [W_SAMPLE-1:0] r_s1_reboot;
    logic                       r_s1_clear;

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_stick[0] <= i_in.roll_in;
            r_s1_stick[1] <= i_in.pitch_in;
            r_s1_stick[2] <= i_in.throttle_in;
            r_s1_stick[3] <= i_in.yaw_in;
            r_s1_mode     <= i_in.mode_switch;
            r_s1_gear     <= i_in.gear_switch;
            r_s1_reboot   <= i_in.reboot_switch;
            r_s1_clear    <= i_in.clear_hover_entry;
        end
    end

    // stick lanes
    logic signed [W_SAMPLE-1:0] stick_y [4];

    for (genvar g = 0; g < 4; g++) begin : g_stick
        rcsd_stick u_stick (
            .i_x         (r_s1_stick[g]),
            .i_dead_zone (r_dead_zone),
            .i_gain      (r_stick_gain),
            .o_y         (stick_y[g])
        );
    end

    // switch state
    logic signed [W_SAMPLE-1:0] r_prev_mode;
    logic signed [W_SAMPLE-1:0] r_prev_gear;
    logic signed [W_SAMPLE-1:0] r_prev_reboot;
    logic                       r_seen_first;
    logic                       r_hover;
    logic                       r_hover_entry;
    logic                       r_command;
    logic                       r_command_entry;

    logic signed [W_SAMPLE-1:0] pm;
    logic signed [W_SAMPLE-1:0] pg;
    logic signed [W_SAMPLE-1:0] pr;
    logic                       n_hover;
    logic                       n_hover_entry;
    logic                       n_command;
    logic                       n_command_entry;
    logic                       n_reboot;
    logic                       n_valid;

    // previous values, seeded from the frame itself on the first one
    assign pm = r_seen_first ? r_prev_mode   : r_s1_mode;
    assign pg = r_seen_first ? r_prev_gear   : r_s1_gear;
    assign pr = r_seen_first ? r_prev_reboot : r_s1_reboot;

    always_comb begin
        // hover and its sticky entry flag
        n_hover_entry = r_s1_clear ? 1'b0 : r_hover_entry;
        if (pm < r_mode_th && r_s1_mode > r_mode_th) begin
            n_hover_entry = 1'b1;
        end
        n_hover = r_s1_mode > r_mode_th;

        // command flags move only in hover
        n_command       = r_command;
        n_command_entry = r_command_entry;
        if (n_hover) begin
            if (pg < r_gear_th && r_s1_gear > r_gear_th) begin
                n_command_entry = 1'b1;
            end else if (r_s1_gear < r_gear_th) begin
                n_command_entry = 1'b0;
            end
            n_command = r_s1_gear > r_gear_th;
        end

        // reboot edge outside hover and command
        n_reboot = !n_hover && !n_command && pr < r_reboot_th && r_s1_reboot > r_reboot_th;

        // range check of the switch channels
        n_valid = r_s1_mode >= -SW_LIMIT && r_s1_mode <= SW_LIMIT
               && r_s1_gear >= -SW_LIMIT && r_s1_gear <= SW_LIMIT
               && r_s1_reboot >= -SW_LIMIT && r_s1_reboot <= SW_LIMIT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_mode     <= '0;
            r_prev_gear     <= '0;
            r_prev_reboot   <= '0;
            r_seen_first    <= 1'b0;
            r_hover         <= 1'b1;
            r_hover_entry   <= 1'b0;
            r_command       <= 1'b1;
            r_command_entry <= 1'b0;
        end else if (s1_adv) begin
            r_prev_mode     <= r_s1_mode;
            r_prev_gear     <= r_s1_gear;
            r_prev_reboot   <= r_s1_reboot;
            r_seen_first    <= 1'b1;
            r_hover         <= n_hover;
            r_hover_entry   <= n_hover_entry;
            r_command       <= n_command;
            r_command_entry <= n_command_entry;
        end
    end

    // result register
    logic signed [W_SAMPLE-1:0] r_out_stick [4];
    logic                       r_out_reboot;
    logic                       r_out_valid_sw;

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_stick[0] <= stick_y[0];
            r_out_stick[1] <= stick_y[1];
            r_out_stick[2] <= stick_y[2];
            r_out_stick[3] <= stick_y[3];
            r_out_reboot   <= n_reboot;
            r_out_valid_sw <= n_valid;
        end
    end

    assign o_out.valid           = r_s2_valid;
    assign o_out.roll_out        = r_out_stick[0];
    assign o_out.pitch_out       = r_out_stick[1];
    assign o_out.throttle_out    = r_out_stick[2];
    assign o_out.yaw_out         = r_out_stick[3];
    assign o_out.hover_active    = r_hover;
    assign o_out.hover_entered   = r_hover_entry;
    assign o_out.command_active  = r_command;
    assign o_out.command_entered = r_command_entry;
    assign o_out.reboot_request  = r_out_reboot;
    assign o_out.switches_valid  = r_out_valid_sw;

`ifndef SYNTHESIS
    // a frame leaving the input register lands in the result register
    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_s2_valid)
        else $error("frame lost between input and result register");

    // reboot never reported while hover or command is active
    a_reboot_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> !(r_out_reboot && (r_hover || r_command)))
        else $error("reboot request during hover or command");

    // state only moves when a frame advances
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_adv |=> $stable(r_seen_first) && $stable(r_hover) && $stable(r_command))
        else $error("switch state changed without a frame");
`endif

endmodule

`default_nettype wire
